[hw/rtl/segx_pkg.sv]
// ----------------------------------------------------------------------------
// segx_pkg: shared constants for segment_intersection_2d
// Default widths and the job queue depth and address width.
// ----------------------------------------------------------------------------
`default_nettype none

package segx_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int FIFO_DEPTH     = 8;
    localparam int FIFO_AW        = 3;

endpackage

`default_nettype wire

[hw/rtl/segx_front.sv]
// ----------------------------------------------------------------------------
// segx_front: cross products and span classification
// Pipelined: differences, partial products, sums, span tests.
// Outputs the classified job: flags, quotient operands, lerp operands.
// ----------------------------------------------------------------------------
`default_nettype none

module segx_front #(
    parameter int COORD_BITS = segx_pkg::COORD_BITS_DEF
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         in_valid,
    input  wire [10*COORD_BITS-1:0]     in_data,
    input  wire                         advance,
    output logic                        out_valid,
    output logic                        out_hit,
    output logic                        out_par,
    output logic [2*COORD_BITS+1:0]     out_num,   // |na|
    output logic [2*COORD_BITS+1:0]     out_den,   // |den|
    output logic [3*(COORD_BITS+1)-1:0] out_diff,  // dax, daz, day
    output logic [3*COORD_BITS-1:0]     out_base   // ax0, az0, ay0
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    // stage 1: differences
    logic                 v1_reg;
    logic signed [DW-1:0] dax_reg, daz_reg, day_reg, dbx_reg, dbz_reg, ox_reg, oz_reg;
    logic [3*COORD_BITS-1:0] base1_reg;
    // stage 2: products
    logic                 v2_reg;
    logic signed [PW-1:0] p_reg [6];
    logic signed [DW-1:0] d2x_reg, d2z_reg, d2y_reg;
    logic [3*COORD_BITS-1:0] base2_reg;
    // stage 3: sums
    logic                 v3_reg;
    logic signed [SW-1:0] den_reg, na_reg, nb_reg;
    logic signed [DW-1:0] d3x_reg, d3z_reg, d3y_reg;
    logic [3*COORD_BITS-1:0] base3_reg;

    function automatic logic signed [DW-1:0] fld(input logic [10*COORD_BITS-1:0] d,
                                                 input int i);
        return DW'($signed(d[i*COORD_BITS +: COORD_BITS]));
    endfunction

    function automatic logic span(input logic signed [SW-1:0] n,
                                  input logic signed [SW-1:0] d);
        return (n >= 0 && n <= d) || (n <= 0 && n >= d);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; out_valid <= 1'b0;
        end else if (advance) begin
            v1_reg <= in_valid; v2_reg <= v1_reg; v3_reg <= v2_reg; out_valid <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            dax_reg <= fld(in_data, 3) - fld(in_data, 0);
            daz_reg <= fld(in_data, 4) - fld(in_data, 1);
            day_reg <= fld(in_data, 5) - fld(in_data, 2);
            dbx_reg <= fld(in_data, 8) - fld(in_data, 6);
            dbz_reg <= fld(in_data, 9) - fld(in_data, 7);
            ox_reg  <= fld(in_data, 0) - fld(in_data, 6);
            oz_reg  <= fld(in_data, 1) - fld(in_data, 7);
            base1_reg <= in_data[3*COORD_BITS-1:0];

            p_reg[0] <= dbz_reg * dax_reg;
            p_reg[1] <= dbx_reg * daz_reg;
            p_reg[2] <= dbx_reg * oz_reg;
            p_reg[3] <= dbz_reg * ox_reg;
            p_reg[4] <= dax_reg * oz_reg;
            p_reg[5] <= daz_reg * ox_reg;
            d2x_reg <= dax_reg; d2z_reg <= daz_reg; d2y_reg <= day_reg;
            base2_reg <= base1_reg;

            den_reg <= SW'(p_reg[0]) - SW'(p_reg[1]);
            na_reg  <= SW'(p_reg[2]) - SW'(p_reg[3]);
            nb_reg  <= SW'(p_reg[4]) - SW'(p_reg[5]);
            d3x_reg <= d2x_reg; d3z_reg <= d2z_reg; d3y_reg <= d2y_reg;
            base3_reg <= base2_reg;

            out_par  <= (den_reg == '0);
            out_hit  <= (den_reg != '0) && span(na_reg, den_reg) && span(nb_reg, den_reg);
            out_num  <= PW'(na_reg[SW-1] ? -na_reg : na_reg);
            out_den  <= PW'(den_reg[SW-1] ? -den_reg : den_reg);
            out_diff <= {d3y_reg, d3z_reg, d3x_reg};
            out_base <= base3_reg;
        end
    end
endmodule

`default_nettype wire

[hw/rtl/segx_fifo.sv]
// ----------------------------------------------------------------------------
// segx_fifo: small job queue between front and back end
// Register-based FIFO with occupancy count for upstream credit.
// ----------------------------------------------------------------------------
`default_nettype none

module segx_fifo #(
    parameter int WIDTH = 8
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              wr_en,
    input  wire [WIDTH-1:0]  wr_data,
    input  wire              rd_en,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data,
    output logic [segx_pkg::FIFO_AW:0] count
);
    localparam int FIFO_CW = segx_pkg::FIFO_AW + 1;
    logic [WIDTH-1:0] mem_reg [segx_pkg::FIFO_DEPTH];
    logic [segx_pkg::FIFO_AW-1:0] wp_reg, rp_reg;
    logic [FIFO_CW-1:0] cnt_reg;

    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rp_reg];
    assign count    = cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= wp_reg + 1'b1;
            if (rd_en) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + FIFO_CW'(wr_en) - FIFO_CW'(rd_en);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end
endmodule

`default_nettype wire

[hw/rtl/segx_back.sv]
// ----------------------------------------------------------------------------
// segx_back: pipelined restoring divider and interpolation
// One quotient bit per stage, then three multiply-shift-add lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module segx_back #(
    parameter int COORD_BITS = segx_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = segx_pkg::FRAC_BITS_DEF
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         advance,
    input  wire                         in_valid,
    input  wire                         in_hit,
    input  wire                         in_par,
    input  wire [2*COORD_BITS+1:0]      in_num,
    input  wire [2*COORD_BITS+1:0]      in_den,
    input  wire [3*(COORD_BITS+1)-1:0]  in_diff,
    input  wire [3*COORD_BITS-1:0]      in_base,
    output logic                        out_valid,
    output logic                        out_hit,
    output logic                        out_par,
    output logic [3*COORD_BITS-1:0]     out_xyz
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int RW = PW + 1;
    localparam int QW = FRAC_BITS + 1;
    localparam int NS = FRAC_BITS + 1;   // stage 1 = load and equality check
    localparam int MW = QW + 1 + DW;

    logic            v_reg   [1:NS];
    logic            h_reg   [1:NS];
    logic            p_reg   [1:NS];
    logic [RW-1:0]   r_reg   [1:NS];
    logic [PW-1:0]   m_reg   [1:NS];
    logic [QW-1:0]   q_reg   [1:NS];
    logic            e_reg   [1:NS];
    logic [3*DW-1:0] d_reg   [1:NS];
    logic [3*COORD_BITS-1:0] b_reg [1:NS];
    logic [RW-1:0]   sh      [1:NS-1];
    logic            ge      [1:NS-1];

    logic signed [MW-1:0] prod_reg [3];
    logic [3*COORD_BITS-1:0] bm_reg;
    logic vm_reg, hm_reg, pm_reg;

    // shifted remainder and trial compare for each quotient bit
    always_comb begin
        for (int s = 1; s < NS; s++) begin
            sh[s] = {r_reg[s][RW-2:0], 1'b0};
            ge[s] = sh[s] >= RW'(m_reg[s]);
        end
    end

    logic [QW-1:0] tq;
    assign tq = e_reg[NS] ? QW'(1) << FRAC_BITS : q_reg[NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 1; s <= NS; s++) v_reg[s] <= 1'b0;
            vm_reg <= 1'b0; out_valid <= 1'b0;
        end else if (advance) begin
            v_reg[1] <= in_valid;
            for (int s = 1; s < NS; s++) v_reg[s+1] <= v_reg[s];
            vm_reg <= v_reg[NS]; out_valid <= vm_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            h_reg[1] <= in_hit; p_reg[1] <= in_par;
            r_reg[1] <= RW'(in_num); m_reg[1] <= in_den; q_reg[1] <= '0;
            e_reg[1] <= (in_num == in_den);
            d_reg[1] <= in_diff; b_reg[1] <= in_base;
            for (int s = 1; s < NS; s++) begin
                h_reg[s+1] <= h_reg[s]; p_reg[s+1] <= p_reg[s];
                m_reg[s+1] <= m_reg[s]; e_reg[s+1] <= e_reg[s];
                d_reg[s+1] <= d_reg[s]; b_reg[s+1] <= b_reg[s];
                r_reg[s+1] <= ge[s] ? sh[s] - RW'(m_reg[s]) : sh[s];
                q_reg[s+1] <= {q_reg[s][QW-2:0], ge[s]};
            end

            hm_reg <= h_reg[NS]; pm_reg <= p_reg[NS]; bm_reg <= b_reg[NS];
            for (int k = 0; k < 3; k++)
                prod_reg[k] <= $signed({1'b0, tq}) * $signed(d_reg[NS][k*DW +: DW]);
            out_hit <= hm_reg; out_par <= pm_reg;
            for (int k = 0; k < 3; k++)
                out_xyz[k*COORD_BITS +: COORD_BITS] <= hm_reg ?
                    COORD_BITS'(prod_reg[k] >>> FRAC_BITS) + bm_reg[k*COORD_BITS +: COORD_BITS]
                    : '0;
        end
    end
endmodule

`default_nettype wire

[hw/rtl/segment_intersection_2d.sv]
// 24 register stages by default (4 front, 1 queue, FRAC_BITS + 1 divider, 2 interpolation).
// The divider has one stage per quotient bit after its load stage.
// Throughput: one transaction per cycle unless m_tready or queue credits hold it.
// The front end feeds a small queue; the back end runs while the output can advance.
// Reset: aresetn synchronous active low clears valid bits, queue pointers and credits only.
// ----------------------------------------------------------------------------
// segment_intersection_2d: 2-D segment crossing test with height interpolation
// Front end forms cross products and span tests, back end divides and lerps.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_2d #(
    parameter int COORD_BITS = segx_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = segx_pkg::FRAC_BITS_DEF
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_tvalid,
    output logic                       s_tready,
    // a_start_x, a_start_z, a_start_y, a_end_x, a_end_z, a_end_y,
    // b_start_x, b_start_z, b_end_x, b_end_z (lowest first)
    input  wire [10*COORD_BITS-1:0]    s_tdata,
    output logic                       m_tvalid,
    input  wire                        m_tready,
    // cross_x, cross_z, cross_y (lowest first)
    output logic [3*COORD_BITS-1:0]    m_tdata,
    // hit, parallel (lowest first)
    output logic [1:0]                 m_tuser
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int JW = 2 + 2 * PW + 3 * DW + 3 * COORD_BITS;
    localparam int CW = segx_pkg::FIFO_AW + 1;
    // Front pipeline holds up to 4 in flight; accept only when queue can absorb them all.
    localparam int FRONT_DEPTH = 4;

    logic f_valid, f_hit, f_par;
    logic [PW-1:0] f_num, f_den;
    logic [3*DW-1:0] f_diff;
    logic [3*COORD_BITS-1:0] f_base;
    logic [CW-1:0] q_count;
    logic [2:0] inflight_reg;
    logic q_valid, q_rd, b_adv;
    logic [JW-1:0] q_data;

    // The front pipeline always advances; credits bound what it can push.
    assign s_tready = (32'(q_count) + 32'(inflight_reg)) < segx_pkg::FIFO_DEPTH;

    always_ff @(posedge aclk) begin
        if (!aresetn) inflight_reg <= '0;
        else inflight_reg <= inflight_reg + 3'(s_tvalid && s_tready) - 3'(f_valid);
    end

    segx_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk, .aresetn, .in_valid(s_tvalid && s_tready), .in_data(s_tdata),
        .advance(1'b1), .out_valid(f_valid), .out_hit(f_hit), .out_par(f_par),
        .out_num(f_num), .out_den(f_den), .out_diff(f_diff), .out_base(f_base)
    );

    segx_fifo #(.WIDTH(JW)) u_fifo (
        .aclk, .aresetn, .wr_en(f_valid),
        .wr_data({f_hit, f_par, f_num, f_den, f_diff, f_base}),
        .rd_en(q_rd), .rd_valid(q_valid), .rd_data(q_data), .count(q_count)
    );

    // Back end stalls as a whole when its output is held.
    assign b_adv = !m_tvalid || m_tready;
    assign q_rd  = q_valid && b_adv;

    segx_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk, .aresetn, .advance(b_adv), .in_valid(q_rd),
        .in_hit(q_data[JW-1]), .in_par(q_data[JW-2]),
        .in_num(q_data[JW-3 -: PW]), .in_den(q_data[JW-3-PW -: PW]),
        .in_diff(q_data[3*COORD_BITS +: 3*DW]), .in_base(q_data[3*COORD_BITS-1:0]),
        .out_valid(m_tvalid), .out_hit(m_tuser[0]), .out_par(m_tuser[1]),
        .out_xyz(m_tdata)
    );

    // FRONT_DEPTH documents the credit window matched to the queue depth.
    if (FRONT_DEPTH > segx_pkg::FIFO_DEPTH) begin : g_bad
        $error("queue too shallow");
    end
endmodule

`default_nettype wire
